[rtl/gtpu_cls_pkg.sv]
`timescale 1ns / 1ps

package gtpu_cls_pkg;

   // Bytes of the GTP-U header between the UDP header and the inner packet.
   localparam int TUNNEL_HEADER_BYTES = 8;

   localparam int UDP_HDR_BYTES = 8;
   // Offset of the source address inside the inner IPv4 header.
   localparam int INNER_SRC_OFFSET = 12;
   localparam int INNER_SRC_GAP = UDP_HDR_BYTES + TUNNEL_HEADER_BYTES + INNER_SRC_OFFSET;

   localparam logic [7:0] OFF_DEST_MAC_END = 8'd6;
   localparam logic [7:0] OFF_ETH_TYPE_HI  = 8'd12;
   localparam logic [7:0] OFF_ETH_TYPE_LO  = 8'd13;
   localparam logic [7:0] OFF_IP_VER_IHL   = 8'd14;
   localparam logic [7:0] OFF_IP_PROTO     = 8'd23;
   localparam logic [7:0] OFF_IP_DEST_FIRST = 8'd30;
   localparam logic [7:0] OFF_IP_DEST_LAST  = 8'd33;
   localparam logic [7:0] OFF_MAX          = 8'hff;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
   localparam logic [7:0]  BROADCAST_BYTE = 8'hff;
   localparam logic [15:0] TUNNEL_UDP_PORT_RESET = 16'd2152;

   localparam logic SIDE_ACCESS  = 1'b0;
   localparam logic ROLE_SERVING = 1'b1;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PORT_SIDE       = 3'd0,
      CSR_GATEWAY_ROLE    = 3'd1,
      CSR_SERVING_GW_ADDR = 3'd2,
      CSR_NETWORK_IF_ADDR = 3'd3,
      CSR_TUNNEL_UDP_PORT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic        port_side;
      logic        gateway_role;
      logic [31:0] serving_gw_addr;
      logic [31:0] network_if_addr;
      logic [15:0] tunnel_udp_port;
   } cfg_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
      logic       checksum_bad;
   } req_type;

   typedef struct packed {
      logic        to_kernel;
      logic [31:0] subscriber_addr;
   } rsp_type;

endpackage

[rtl/gtpu_cls_csr.sv]
`timescale 1ns / 1ps

module gtpu_cls_csr import gtpu_cls_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PORT_SIDE:       cfg_in.port_side       = csr_wdata[0];
            CSR_GATEWAY_ROLE:    cfg_in.gateway_role    = csr_wdata[0];
            CSR_SERVING_GW_ADDR: cfg_in.serving_gw_addr = csr_wdata;
            CSR_NETWORK_IF_ADDR: cfg_in.network_if_addr = csr_wdata;
            CSR_TUNNEL_UDP_PORT: cfg_in.tunnel_udp_port = csr_wdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port_side       <= SIDE_ACCESS;
         cfg_ff.gateway_role    <= ROLE_SERVING;
         cfg_ff.serving_gw_addr <= '0;
         cfg_ff.network_if_addr <= '0;
         cfg_ff.tunnel_udp_port <= TUNNEL_UDP_PORT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/gtpu_cls_parse.sv]
`timescale 1ns / 1ps

module gtpu_cls_parse import gtpu_cls_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type beat,
   input  cfg_type cfg,
   output rsp_type verdict
);

   logic [7:0]  byte_offset_ff, byte_offset_in;
   logic [5:0]  ip_header_len_ff, ip_header_len_in;
   logic [15:0] ether_kind_ff, ether_kind_in;
   logic        all_ones_dest_ff, all_ones_dest_in;
   logic [7:0]  ip_protocol_ff, ip_protocol_in;
   logic [31:0] outer_dest_addr_ff, outer_dest_addr_in;
   logic [15:0] udp_dest_port_ff, udp_dest_port_in;
   logic [31:0] inner_source_addr_ff, inner_source_addr_in;
   logic        checksum_fail_ff, checksum_fail_in;

   logic [7:0] o;
   logic [7:0] b;
   logic [6:0] udp_base;
   logic [7:0] inner_start;
   logic       fast;
   logic [31:0] addr;

   assign o = byte_offset_ff;
   assign b = beat.frame_byte;

   // The header length byte sits well before any offset derived from it, so
   // the stored length is always the one in force here.
   assign udp_base    = 7'(OFF_IP_VER_IHL) + {1'b0, ip_header_len_ff};
   assign inner_start = {1'b0, udp_base} + 8'(INNER_SRC_GAP);

   always_comb begin
      checksum_fail_in     = checksum_fail_ff | beat.checksum_bad;
      all_ones_dest_in     = all_ones_dest_ff;
      ether_kind_in        = ether_kind_ff;
      ip_header_len_in     = ip_header_len_ff;
      ip_protocol_in       = ip_protocol_ff;
      outer_dest_addr_in   = outer_dest_addr_ff;
      udp_dest_port_in     = udp_dest_port_ff;
      inner_source_addr_in = inner_source_addr_ff;

      if (o < OFF_DEST_MAC_END && b != BROADCAST_BYTE) all_ones_dest_in = 1'b0;
      if (o == OFF_ETH_TYPE_HI) ether_kind_in = {b, 8'h00};
      if (o == OFF_ETH_TYPE_LO) ether_kind_in = {ether_kind_ff[15:8], b};
      if (o == OFF_IP_VER_IHL)  ip_header_len_in = {b[3:0], 2'b00};
      if (o == OFF_IP_PROTO)    ip_protocol_in = b;
      if (o >= OFF_IP_DEST_FIRST && o <= OFF_IP_DEST_LAST) begin
         outer_dest_addr_in = {outer_dest_addr_ff[23:0], b};
      end
      if (o == {1'b0, udp_base} + 8'd2 || o == {1'b0, udp_base} + 8'd3) begin
         udp_dest_port_in = {udp_dest_port_ff[7:0], b};
      end
      if (o >= inner_start && o <= inner_start + 8'd3) begin
         inner_source_addr_in = {inner_source_addr_ff[23:0], b};
      end

      byte_offset_in = (o != OFF_MAX) ? o + 8'd1 : o;
   end

   // Verdict on the last byte, taken from the fields as updated by that byte.
   always_comb begin
      fast = 1'b0;
      addr = '0;
      if (!checksum_fail_in && ether_kind_in == ETHERTYPE_IPV4) begin
         if (cfg.port_side == SIDE_ACCESS) begin
            if (ip_protocol_in == IP_PROTO_UDP && udp_dest_port_in == cfg.tunnel_udp_port
                && o >= inner_start + 8'd3) begin
               fast = 1'b1;
               addr = inner_source_addr_in;
            end
         end else if (!all_ones_dest_in && o >= OFF_IP_DEST_LAST) begin
            if (cfg.gateway_role == ROLE_SERVING) begin
               fast = (outer_dest_addr_in == cfg.serving_gw_addr);
            end else begin
               fast = (outer_dest_addr_in != cfg.network_if_addr);
            end
            if (fast) addr = outer_dest_addr_in;
         end
      end
      verdict.to_kernel       = ~fast;
      verdict.subscriber_addr = addr;
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && beat.frame_last)) begin
         byte_offset_ff       <= '0;
         ip_header_len_ff     <= '0;
         ether_kind_ff        <= '0;
         all_ones_dest_ff     <= 1'b1;
         ip_protocol_ff       <= '0;
         outer_dest_addr_ff   <= '0;
         udp_dest_port_ff     <= '0;
         inner_source_addr_ff <= '0;
         checksum_fail_ff     <= 1'b0;
      end else if (step_en) begin
         byte_offset_ff       <= byte_offset_in;
         ip_header_len_ff     <= ip_header_len_in;
         ether_kind_ff        <= ether_kind_in;
         all_ones_dest_ff     <= all_ones_dest_in;
         ip_protocol_ff       <= ip_protocol_in;
         outer_dest_addr_ff   <= outer_dest_addr_in;
         udp_dest_port_ff     <= udp_dest_port_in;
         inner_source_addr_ff <= inner_source_addr_in;
         checksum_fail_ff     <= checksum_fail_in;
      end
   end

endmodule

[rtl/gtpu_uplink_downlink_classifier.sv]
`timescale 1ns / 1ps
//  Channel   Direction  Handshake             Payload
//  req_      in         req_valid/req_stall   req_payload (frame byte, last, checksum flag)
//  rsp_      out        rsp_valid/rsp_stall   rsp_payload (to_kernel, subscriber address)
//  csr_      in         csr_wr_en             csr_index, csr_wdata
//
//  One frame byte is taken every cycle while the input register is not held; a
//  verdict is loaded into the result register when the frame's last byte leaves
//  the input register, the parser working combinationally between the two.
//  Synchronous reset restores the config and parser defaults and empties both stages.
//  While a verdict waits under rsp_stall, ordinary bytes keep flowing; only a
//  frame's last beat is held in the input register until the result register frees.

module gtpu_uplink_downlink_classifier import gtpu_cls_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type cfg;
   rsp_type verdict;

   logic    in_valid_ff, in_valid_in;
   req_type in_beat_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;

   logic out_free;
   logic advance;
   logic req_accept;

   gtpu_cls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gtpu_cls_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .beat    (in_beat_ff),
      .cfg     (cfg),
      .verdict (verdict)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && (!in_beat_ff.frame_last || out_free);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_accept || (in_valid_ff && !advance);
      if (advance && in_beat_ff.frame_last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) in_beat_ff <= req_payload;
      if (advance && in_beat_ff.frame_last) rsp_payload_ff <= verdict;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
